// ----- design/dip_pkg.sv -----
package dip_pkg;

    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 18;
    localparam int VALUE_W = 32;
    // Magnitude times ten plus a digit needs four more bits than the accumulator
    localparam int PROD_W  = VALUE_W + 4;

    localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_FAIL   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              byte_present;
        logic              is_last;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]      magnitude;
        logic                    negative;
        logic                    ok;
        logic signed [CFG_W-1:0] default_value;
    } t_result;

endpackage

// ----- design/dip_in_if.sv -----
interface dip_in_if;
    import dip_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              byte_present;
    logic              is_last;

    modport source (output valid, output text_byte, output byte_present, output is_last,
                    input ready);
    modport sink   (input valid, input text_byte, input byte_present, input is_last,
                    output ready);
endinterface

// ----- design/dip_out_if.sv -----
interface dip_out_if;
    import dip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      parsed_ok;

    modport source (output valid, output value, output parsed_ok, input ready);
    modport sink   (input valid, input value, input parsed_ok, output ready);
endinterface

// ----- design/dip_in_stage.sv -----
module dip_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dip_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output dip_pkg::t_in_item o_item
);
    import dip_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Accept when empty or when the held byte is consumed this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload on every transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ----- design/dip_parse.sv -----
module dip_parse (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  dip_pkg::t_in_item                i_item,
    input  logic                             i_out_free,
    input  logic signed [dip_pkg::CFG_W-1:0] i_default,
    output logic                             o_take,
    output logic                             o_emit,
    output dip_pkg::t_result                 o_result
);
    import dip_pkg::*;

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic               r_big, n_big;
    logic [PROD_W-1:0]  prod;
    logic [BYTE_W-1:0]  b;

    assign b = i_item.text_byte;

    // Consume a non-final byte at once; a final byte waits for a free result slot
    assign o_take = i_valid && (!i_item.is_last || i_out_free);
    assign o_emit = o_take && i_item.is_last;

    // Accumulator times ten plus the digit value
    assign prod = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
                + {{(PROD_W-4){1'b0}}, b[3:0]};

    // Advance the parse phase by one byte
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_big   = r_big;
        if (i_item.byte_present && r_phase != PH_FAIL) begin
            if (b == CH_SPACE || b inside {[CH_TAB:CH_CR]}) begin
                case (r_phase)
                    PH_SIGN:   n_phase = PH_FAIL;
                    PH_DIGITS: n_phase = PH_TRAIL;
                    default:   n_phase = r_phase;
                endcase
            end else if (b == CH_PLUS || b == CH_MINUS) begin
                if (r_phase == PH_LEAD) begin
                    n_phase = PH_SIGN;
                    n_neg   = (b == CH_MINUS);
                end else begin
                    n_phase = PH_FAIL;
                end
            end else if (b inside {[CH_ZERO:CH_NINE]}) begin
                if (r_phase == PH_TRAIL) begin
                    n_phase = PH_FAIL;
                end else begin
                    n_phase = PH_DIGITS;
                    // Hold the accumulator once it would pass the limit
                    if (prod > {4'b0, MAG_LIMIT}) begin
                        n_big = 1'b1;
                    end else begin
                        n_mag = prod[VALUE_W-1:0];
                    end
                end
            end else begin
                n_phase = PH_FAIL;
            end
        end
    end

    // Build the result from the state after the final byte
    always_comb begin
        o_result.magnitude     = n_mag;
        o_result.negative      = n_neg;
        o_result.default_value = i_default;
        o_result.ok            = (n_phase == PH_DIGITS || n_phase == PH_TRAIL) && !n_big
                                 && !(!n_neg && n_mag[VALUE_W-1]);
    end

    // Update state; clear it after the final byte of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_big   <= 1'b0;
        end else if (o_take) begin
            if (i_item.is_last) begin
                r_phase <= PH_LEAD;
                r_neg   <= 1'b0;
                r_mag   <= '0;
                r_big   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_mag   <= n_mag;
                r_big   <= n_big;
            end
        end
    end

    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag <= MAG_LIMIT)
        else $error("accumulator passed the limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_phase == PH_LEAD && r_mag == '0 && !r_big && !r_neg))
        else $error("parse state not cleared after final byte");

    a_big_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_big |-> (r_phase == PH_DIGITS || r_phase == PH_TRAIL || r_phase == PH_FAIL))
        else $error("overflow flag outside a digit phase");
endmodule

// ----- design/dip_out_stage.sv -----
module dip_out_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  dip_pkg::t_result                   i_result,
    input  logic                               i_ready,
    output logic                               o_free,
    output logic                               o_valid,
    output logic signed [dip_pkg::VALUE_W-1:0] o_value,
    output logic                               o_parsed_ok
);
    import dip_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Slot frees when empty or when the held result transfers
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    // Apply the sign, or fall back to the sign-extended default
    always_comb begin
        if (r_res.ok) begin
            o_value = r_res.negative ? signed'(32'd0 - r_res.magnitude)
                                     : signed'(r_res.magnitude);
        end else begin
            o_value = VALUE_W'(r_res.default_value);
        end
    end

    assign o_valid     = r_valid;
    assign o_parsed_ok = r_res.ok;
endmodule

// ----- design/decimal_int32_text_parser_core.sv -----
// Parses a decimal int32 from a byte stream, one character per transfer with a last mark.
// Leading/trailing whitespace (9..13, 32), one optional sign and decimal digits are accepted;
// on the last byte one result carries the value and parsed_ok, or the sign-extended
// default_value with parsed_ok low. Throughput is one byte per cycle while no final byte
// stalls, set by the multiply-by-ten-and-add accumulator loop. A result becomes valid once
// its last byte has passed through the input register and the result register has loaded it,
// and the input keeps taking bytes while a result waits; only a final byte stalls on a full
// result register. Write default_value only while no text is in flight.
module decimal_int32_text_parser_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dip_in_if.sink                           i_text,
    dip_out_if.source                        o_result,
    input  logic                             i_cfg_we,
    input  logic signed [dip_pkg::CFG_W-1:0] i_cfg_wdata
);
    import dip_pkg::*;

    logic signed [CFG_W-1:0] r_default;
    t_in_item                in_item;
    t_in_item                held_item;
    t_result                 result;
    logic                    held_valid;
    logic                    take;
    logic                    emit;
    logic                    out_free;

    // Hold the configured default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
        end else if (i_cfg_we) begin
            r_default <= i_cfg_wdata;
        end
    end

    assign in_item.text_byte    = i_text.text_byte;
    assign in_item.byte_present = i_text.byte_present;
    assign in_item.is_last      = i_text.is_last;

    dip_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_text.valid),
        .o_ready (i_text.ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    dip_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_item     (held_item),
        .i_out_free (out_free),
        .i_default  (r_default),
        .o_take     (take),
        .o_emit     (emit),
        .o_result   (result)
    );

    dip_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit),
        .i_result    (result),
        .i_ready     (o_result.ready),
        .o_free      (out_free),
        .o_valid     (o_result.valid),
        .o_value     (o_result.value),
        .o_parsed_ok (o_result.parsed_ok)
    );
endmodule
